@@ rtl/phfbe_pkg.sv @@
// ----------------------------------------------------------------------------
// phfbe_pkg: shared types and constants of the fragment bandwidth estimator
// ----------------------------------------------------------------------------
`default_nettype none
package phfbe_pkg;
  localparam int unsigned HostEntriesDef = 16;
  localparam int unsigned AddrW = 48;
  localparam int unsigned TimeW = 48;
  localparam int unsigned NumW  = 16;
  localparam int unsigned BwW   = 36;
  localparam int unsigned SlotOutW = 4;
  localparam logic [19:0] UsPerSec = 20'd1000000;
  localparam int unsigned DivStepW = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic search_step;
    logic decide;
    logic div_start;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic search_done;
    logic need_div;
    logic div_done;
  } sts_t;
endpackage
`default_nettype wire

@@ rtl/phfbe_datapath.sv @@
// ----------------------------------------------------------------------------
// phfbe_datapath: host table, serial search and restoring divider
// ----------------------------------------------------------------------------
`default_nettype none
module phfbe_datapath import phfbe_pkg::*; #(
  parameter int unsigned HostEntries = HostEntriesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  input  wire logic [AddrW-1:0]    host_address_i,
  input  wire logic [NumW-1:0]     stream_number_i,
  input  wire logic [NumW-1:0]     block_number_i,
  input  wire logic [NumW-1:0]     fragment_number_i,
  input  wire logic                consecutive_flag_i,
  input  wire logic [TimeW-1:0]    arrival_time_us_i,
  input  wire logic [NumW-1:0]     byte_count_i,
  output logic                     sample_valid_o,
  output logic [BwW-1:0]           bandwidth_bps_o,
  output logic [TimeW-1:0]         sample_time_us_o,
  output logic [SlotOutW-1:0]      host_slot_o,
  output logic                     new_host_o,
  output logic                     table_full_drop_o
);
  localparam int unsigned IdxW = (HostEntries > 1) ? $clog2(HostEntries) : 1;
  localparam int unsigned CntW = $clog2(HostEntries + 1);
  localparam int unsigned NumerW = 36;

  logic [HostEntries-1:0] valid_q;
  logic [AddrW-1:0] addr_q [HostEntries];
  logic [NumW-1:0]  strm_q [HostEntries];
  logic [NumW-1:0]  blk_q  [HostEntries];
  logic [NumW-1:0]  frag_q [HostEntries];
  logic [TimeW-1:0] time_q [HostEntries];

  logic [AddrW-1:0] in_addr_q;
  logic [NumW-1:0]  in_strm_q, in_blk_q, in_frag_q, in_bytes_q;
  logic             in_consec_q;
  logic [TimeW-1:0] in_time_q;

  logic [CntW-1:0] idx_q;
  logic            found_q, free_q;
  logic [IdxW-1:0] found_idx_q, free_idx_q;

  logic [IdxW-1:0] cur;
  assign cur = idx_q[IdxW-1:0];

  // divider: 36-bit numerator over 48-bit gap
  logic [NumerW-1:0] quo_q;
  logic [TimeW-1:0]  rem_q;
  logic [TimeW-1:0]  gap_q;
  logic [DivStepW-1:0] dcnt_q;
  logic [TimeW:0]    trial;
  logic [TimeW:0]    shifted;
  logic              zero_gap_q, need_div_q;

  assign shifted = {rem_q, quo_q[NumerW-1]};
  assign trial   = shifted - {1'b0, gap_q};

  assign sts_o.search_done = (idx_q == CntW'(HostEntries));
  assign sts_o.need_div    = need_div_q;
  assign sts_o.div_done    = (dcnt_q == DivStepW'(NumerW));

  logic [TimeW-1:0] gap;
  logic             hit;
  assign gap = in_time_q - time_q[found_idx_q];
  assign hit = found_q && (strm_q[found_idx_q] == in_strm_q) &&
               (blk_q[found_idx_q] == in_blk_q) &&
               ({1'b0, frag_q[found_idx_q]} + 17'd1 == {1'b0, in_frag_q}) && in_consec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      idx_q <= '0;
      found_q <= 1'b0;
      free_q <= 1'b0;
      sample_valid_o <= 1'b0;
      new_host_o <= 1'b0;
      table_full_drop_o <= 1'b0;
      need_div_q <= 1'b0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        in_addr_q <= host_address_i;
        in_strm_q <= stream_number_i;
        in_blk_q <= block_number_i;
        in_frag_q <= fragment_number_i;
        in_consec_q <= consecutive_flag_i;
        in_time_q <= arrival_time_us_i;
        in_bytes_q <= byte_count_i;
        idx_q <= '0;
        found_q <= 1'b0;
        free_q <= 1'b0;
        found_idx_q <= '0;
        free_idx_q <= '0;
      end
      if (cmd_i.search_step) begin
        if (valid_q[cur]) begin
          if (!found_q && addr_q[cur] == in_addr_q) begin
            found_q <= 1'b1;
            found_idx_q <= cur;
          end
        end else if (!free_q) begin
          free_q <= 1'b1;
          free_idx_q <= cur;
        end
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.decide) begin
        sample_valid_o <= hit;
        new_host_o <= !found_q && free_q;
        table_full_drop_o <= !found_q && !free_q;
        host_slot_o <= found_q ? SlotOutW'(found_idx_q) :
                       free_q ? SlotOutW'(free_idx_q) : '0;
        sample_time_us_o <= hit ? in_time_q : '0;
        bandwidth_bps_o <= (hit && gap == '0) ? '1 : '0;
        need_div_q <= hit && (gap != '0);
        zero_gap_q <= (gap == '0);
        gap_q <= gap;
        if (found_q || free_q) begin
          valid_q[found_q ? found_idx_q : free_idx_q] <= 1'b1;
          addr_q[found_q ? found_idx_q : free_idx_q] <= in_addr_q;
          strm_q[found_q ? found_idx_q : free_idx_q] <= in_strm_q;
          blk_q[found_q ? found_idx_q : free_idx_q] <= in_blk_q;
          frag_q[found_q ? found_idx_q : free_idx_q] <= in_frag_q;
          time_q[found_q ? found_idx_q : free_idx_q] <= in_time_q;
        end
      end
      if (cmd_i.div_start) begin
        // bytes * 1e6 fits in 36 bits
        quo_q <= NumerW'({20'd0, in_bytes_q} * {16'd0, UsPerSec});
        rem_q <= '0;
        dcnt_q <= '0;
      end
      if (cmd_i.div_step) begin
        // the partial remainder stays below the gap, so 48 bits hold it
        if (!trial[TimeW]) begin
          rem_q <= trial[TimeW-1:0];
          quo_q <= {quo_q[NumerW-2:0], 1'b1};
        end else begin
          rem_q <= shifted[TimeW-1:0];
          quo_q <= {quo_q[NumerW-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q + 1'b1;
      end
      if (cmd_i.emit && need_div_q && !zero_gap_q) begin
        bandwidth_bps_o <= quo_q;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/phfbe_ctrl.sv @@
// ----------------------------------------------------------------------------
// phfbe_ctrl: sequencer for search, update, divide and result strobe
// ----------------------------------------------------------------------------
`default_nettype none
module phfbe_ctrl import phfbe_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      busy_o,
  output logic      done_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts_i.search_done) state_d = ST_DECIDE;
        else cmd_o.search_step = 1'b1;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (!sts_i.need_div || sts_i.div_done) begin
          cmd_o.emit = 1'b1;
          state_d = ST_EMIT;
        end else cmd_o.div_step = 1'b1;
      end
      ST_EMIT: begin
        done_o = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/per_host_fragment_bandwidth_estimator.sv @@
// ----------------------------------------------------------------------------
// per_host_fragment_bandwidth_estimator: packet-pair bandwidth per sender
// ----------------------------------------------------------------------------
// a fragment is taken when start_i is high and busy_o is low. the sender is
// searched one host entry per cycle, then the entry is claimed or updated and,
// for a fragment that follows the previous one of its stream and block and is
// marked consecutive, a restoring divider computes bytes*1e6/gap one quotient
// bit per cycle; a zero gap saturates the bandwidth instead. one result per
// fragment appears for exactly one cycle with done_o high; the receiver cannot
// stall it. the steps are search, decide, divide (for a sample with a nonzero
// gap) and emit; busy_o stays high throughout. a full table drops an unknown
// sender and flags table_full_drop_o. bandwidth and sample time read 0 when no
// sample is produced, and the host slot reads 0 when the fragment is dropped.
// ----------------------------------------------------------------------------
`default_nettype none
module per_host_fragment_bandwidth_estimator import phfbe_pkg::*; #(
  parameter int unsigned HOST_ENTRIES = HostEntriesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  output logic                     done_o,
  input  wire logic [AddrW-1:0]    host_address_i,
  input  wire logic [NumW-1:0]     stream_number_i,
  input  wire logic [NumW-1:0]     block_number_i,
  input  wire logic [NumW-1:0]     fragment_number_i,
  input  wire logic                consecutive_flag_i,
  input  wire logic [TimeW-1:0]    arrival_time_us_i,
  input  wire logic [NumW-1:0]     byte_count_i,
  output logic                     sample_valid_o,
  output logic [BwW-1:0]           bandwidth_bps_o,
  output logic [TimeW-1:0]         sample_time_us_o,
  output logic [SlotOutW-1:0]      host_slot_o,
  output logic                     new_host_o,
  output logic                     table_full_drop_o
);
  cmd_t cmd;
  sts_t sts;

  // sequencer
  phfbe_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i,
    .sts_i(sts), .cmd_o(cmd), .busy_o, .done_o
  );

  // host table and divider
  phfbe_datapath #(.HostEntries(HOST_ENTRIES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .host_address_i, .stream_number_i, .block_number_i, .fragment_number_i,
    .consecutive_flag_i, .arrival_time_us_i, .byte_count_i,
    .sample_valid_o, .bandwidth_bps_o, .sample_time_us_o, .host_slot_o,
    .new_host_o, .table_full_drop_o
  );
endmodule
`default_nettype wire

@@ rtl/phfbe_checker.sv @@
// ----------------------------------------------------------------------------
// phfbe_checker: port-level checks of the estimator
// ----------------------------------------------------------------------------
`default_nettype none
module phfbe_port_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic done_o,
  input wire logic sample_valid_o,
  input wire logic new_host_o,
  input wire logic table_full_drop_o
);
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accept without busy");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("done outside transaction");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $countones({sample_valid_o, new_host_o, table_full_drop_o}) <= 1)
    else $error("conflicting result flags");
endmodule

bind per_host_fragment_bandwidth_estimator phfbe_port_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o,
  .sample_valid_o, .new_host_o, .table_full_drop_o
);
`default_nettype wire

@@ tb/phfbe_checker.sv @@
// ----------------------------------------------------------------------------
// phfbe_checker: bandwidth sample predictor and result scoreboard
// ----------------------------------------------------------------------------
// watches the fragment and result channels of the estimator, keeps its own
// copy of the host table, predicts one result per accepted fragment and
// compares every strobed result field by field against the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none
module phfbe_checker import phfbe_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic                busy_o,
  input  wire logic                done_o,
  input  wire logic [AddrW-1:0]    host_address_i,
  input  wire logic [NumW-1:0]     stream_number_i,
  input  wire logic [NumW-1:0]     block_number_i,
  input  wire logic [NumW-1:0]     fragment_number_i,
  input  wire logic                consecutive_flag_i,
  input  wire logic [TimeW-1:0]    arrival_time_us_i,
  input  wire logic [NumW-1:0]     byte_count_i,
  input  wire logic                sample_valid_o,
  input  wire logic [BwW-1:0]      bandwidth_bps_o,
  input  wire logic [TimeW-1:0]    sample_time_us_o,
  input  wire logic [SlotOutW-1:0] host_slot_o,
  input  wire logic                new_host_o,
  input  wire logic                table_full_drop_o,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o,
  output int unsigned              sample_count_o,
  output int unsigned              drop_count_o
);
  localparam int unsigned Hosts = HostEntriesDef;

  typedef struct packed {
    logic                sample_valid;
    logic [BwW-1:0]      bandwidth_bps;
    logic [TimeW-1:0]    sample_time_us;
    logic [SlotOutW-1:0] host_slot;
    logic                new_host;
    logic                table_full_drop;
  } bw_result_t;

  logic [Hosts-1:0] host_used;
  logic [AddrW-1:0] host_addr   [Hosts];
  logic [NumW-1:0]  prev_stream [Hosts];
  logic [NumW-1:0]  prev_block  [Hosts];
  logic [NumW-1:0]  prev_frag   [Hosts];
  logic [TimeW-1:0] prev_time   [Hosts];

  bw_result_t expected_results[$];

  // one prediction step of the host table
  function automatic bw_result_t estimate_bandwidth();
    bw_result_t  r;
    int          hit;
    int          vacant;
    logic [TimeW-1:0] gap;
    logic [63:0] quot;
    r = '0;
    hit = -1;
    vacant = -1;
    for (int i = 0; i < Hosts; i++) begin
      if (host_used[i]) begin
        if (hit < 0 && host_addr[i] == host_address_i) hit = i;
      end else if (vacant < 0) begin
        vacant = i;
      end
    end
    if (hit < 0) begin
      if (vacant < 0) begin
        r.table_full_drop = 1'b1;
        return r;
      end
      hit = vacant;
      r.new_host = 1'b1;
      host_used[hit] = 1'b1;
      host_addr[hit] = host_address_i;
    end else if (prev_stream[hit] == stream_number_i && prev_block[hit] == block_number_i
                 && {1'b0, prev_frag[hit]} + 17'd1 == {1'b0, fragment_number_i}
                 && consecutive_flag_i) begin
      gap = arrival_time_us_i - prev_time[hit];
      if (gap == '0) begin
        r.bandwidth_bps = '1;
      end else begin
        quot = (64'(byte_count_i) * 64'(UsPerSec)) / 64'(gap);
        r.bandwidth_bps = (quot > 64'(36'hF_FFFF_FFFF)) ? '1 : quot[BwW-1:0];
      end
      r.sample_valid   = 1'b1;
      r.sample_time_us = arrival_time_us_i;
    end
    r.host_slot = hit[SlotOutW-1:0];
    prev_stream[hit] = stream_number_i;
    prev_block[hit]  = block_number_i;
    prev_frag[hit]   = fragment_number_i;
    prev_time[hit]   = arrival_time_us_i;
    return r;
  endfunction

  task automatic report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch %s expected %0h actual %0h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bw_result_t e;
    if (!rst_ni) begin
      host_used = '0;
      expected_results.delete();
      fail_count_o = 0;
      sample_count_o = 0;
      drop_count_o = 0;
    end else begin
      // result strobe first: it belongs to a transaction accepted earlier
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual slot %0h",
                   $time, host_slot_o);
          fail_count_o++;
        end else begin
          e = expected_results.pop_front();
          report_field("sample_valid", e.sample_valid, sample_valid_o);
          report_field("bandwidth_bps", e.bandwidth_bps, bandwidth_bps_o);
          report_field("sample_time_us", e.sample_time_us, sample_time_us_o);
          report_field("host_slot", e.host_slot, host_slot_o);
          report_field("new_host", e.new_host, new_host_o);
          report_field("table_full_drop", e.table_full_drop, table_full_drop_o);
          sample_count_o += e.sample_valid;
          drop_count_o += e.table_full_drop;
        end
      end
      if (start_i && !busy_o) expected_results.push_back(estimate_bandwidth());
    end
    pending_o = expected_results.size();
  end
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: fragment bandwidth estimator testbench
// ----------------------------------------------------------------------------
// fills the host table with a fixed pool of senders, runs directed corner
// fragments, then random fragment trains per sender with random gaps, plus
// unknown senders that hit the full table; the checker scores every result
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import phfbe_pkg::*;

  localparam int unsigned PoolSize   = HostEntriesDef;
  localparam int unsigned RandItems  = 1200;
  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [AddrW-1:0] host_address_i = '0;
  logic [NumW-1:0]  stream_number_i = '0;
  logic [NumW-1:0]  block_number_i = '0;
  logic [NumW-1:0]  fragment_number_i = '0;
  logic             consecutive_flag_i = 1'b0;
  logic [TimeW-1:0] arrival_time_us_i = '0;
  logic [NumW-1:0]  byte_count_i = '0;

  logic busy_o, done_o, sample_valid_o, new_host_o, table_full_drop_o;
  logic [BwW-1:0]      bandwidth_bps_o;
  logic [TimeW-1:0]    sample_time_us_o;
  logic [SlotOutW-1:0] host_slot_o;

  int unsigned fail_count, pending, sample_count, drop_count;
  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;

  // per-sender history used to build well-formed fragment trains
  logic [AddrW-1:0] pool_addr   [PoolSize];
  logic [NumW-1:0]  pool_stream [PoolSize];
  logic [NumW-1:0]  pool_block  [PoolSize];
  logic [NumW-1:0]  pool_frag   [PoolSize];
  logic [TimeW-1:0] pool_time   [PoolSize];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  per_host_fragment_bandwidth_estimator i_dut (.*);

  phfbe_checker i_checker (
    .clk_i, .rst_ni, .start_i, .busy_o, .done_o,
    .host_address_i, .stream_number_i, .block_number_i, .fragment_number_i,
    .consecutive_flag_i, .arrival_time_us_i, .byte_count_i,
    .sample_valid_o, .bandwidth_bps_o, .sample_time_us_o, .host_slot_o,
    .new_host_o, .table_full_drop_o,
    .fail_count_o(fail_count), .pending_o(pending),
    .sample_count_o(sample_count), .drop_count_o(drop_count)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // drive one fragment and hold it until the transaction is taken
  task automatic send_fragment(logic [AddrW-1:0] addr, logic [NumW-1:0] strm,
                               logic [NumW-1:0] blk, logic [NumW-1:0] frag,
                               logic consec, logic [TimeW-1:0] t,
                               logic [NumW-1:0] bytes, bit allow_idle);
    int unsigned idle;
    // idle while the block is ready, so the gap is seen on the port
    if (allow_idle && $urandom_range(0, 99) < 16) begin
      start_i <= 1'b0;
      do @(negedge clk_i); while (busy_o);
      idle = $urandom_range(1, 8);
      repeat (idle) @(posedge clk_i);
    end
    start_i            <= 1'b1;
    host_address_i     <= addr;
    stream_number_i    <= strm;
    block_number_i     <= blk;
    fragment_number_i  <= frag;
    consecutive_flag_i <= consec;
    arrival_time_us_i  <= t;
    byte_count_i       <= bytes;
    // busy only moves on rising edges, so the falling edge gives a clean look
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    sent_count++;
  endtask

  // send for pool sender p and remember what it sent
  task automatic send_pool(int p, logic [NumW-1:0] strm, logic [NumW-1:0] blk,
                           logic [NumW-1:0] frag, logic consec,
                           logic [TimeW-1:0] t, logic [NumW-1:0] bytes,
                           bit allow_idle);
    send_fragment(pool_addr[p], strm, blk, frag, consec, t, bytes, allow_idle);
    pool_stream[p] = strm;
    pool_block[p]  = blk;
    pool_frag[p]   = frag;
    pool_time[p]   = t;
  endtask

  initial begin
    int p;
    int kind;
    logic [TimeW-1:0] gap;
    logic [NumW-1:0]  frag;

    for (int i = 0; i < PoolSize; i++) begin
      pool_addr[i] = {$urandom(), 16'($urandom())};
    end
    // address extremes live in the pool so they are seen on every path but the table-full drop
    pool_addr[0] = '0;
    pool_addr[1] = '1;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: claim every entry, lowest free one first
    for (int i = 0; i < PoolSize; i++) begin
      send_pool(i, 16'(i), 16'(i), 16'd0, 1'b1, 48'(1000 * i), 16'd100, 1'b0);
    end
    // table full: unknown sender is dropped
    send_fragment(48'h0123_4567_89AB, '1, '1, '1, 1'b1, '1, '1, 1'b0);
    // plain follow-on with the largest byte count
    send_pool(2, 16'd2, 16'd2, 16'd1, 1'b1, 48'd3000, '1, 1'b0);
    // zero gap saturates
    send_pool(2, 16'd2, 16'd2, 16'd2, 1'b1, 48'd3000, 16'd1, 1'b0);
    // not marked consecutive: no sample
    send_pool(2, 16'd2, 16'd2, 16'd3, 1'b0, 48'd3500, 16'd10, 1'b0);
    // stream mismatch and block mismatch
    send_pool(2, 16'd9, 16'd2, 16'd4, 1'b1, 48'd3600, 16'd10, 1'b0);
    send_pool(2, 16'd9, 16'd7, 16'd5, 1'b1, 48'd3700, 16'd10, 1'b0);
    // time going backward wraps the gap
    send_pool(2, 16'd9, 16'd7, 16'd6, 1'b1, 48'd10, 16'd0, 1'b0);
    // last fragment at its maximum is never followed, 0 after it gives nothing
    send_pool(1, '1, '1, '1, 1'b1, '1, '1, 1'b0);
    send_pool(1, '1, '1, 16'd0, 1'b1, 48'd5, '1, 1'b0);
    // largest gap on the zero address
    send_pool(0, 16'd0, 16'd0, 16'd1, 1'b1, 48'(0) - 48'd1, '1, 1'b0);

    // random: mostly fragment trains per sender, some noise and strangers
    for (int n = 0; n < RandItems; n++) begin
      p = $urandom_range(0, PoolSize - 1);
      kind = $urandom_range(0, 99);
      // one long stretch goes back to back with no idling
      if (kind < 70) begin
        frag = pool_frag[p] + 16'd1;
        case ($urandom_range(0, 19))
          0: gap = '0;
          1: gap = {$urandom(), 16'($urandom())};
          default: gap = 48'($urandom_range(1, 5000));
        endcase
        send_pool(p, pool_stream[p], pool_block[p], frag, $urandom_range(0, 9) != 0,
                  pool_time[p] + gap, 16'($urandom()), !(n >= 400 && n < 600));
      end else if (kind < 85) begin
        send_pool(p, 16'($urandom()), 16'($urandom()), 16'($urandom_range(0, 3)),
                  1'b1, {$urandom(), 16'($urandom())}, 16'($urandom()),
                  !(n >= 400 && n < 600));
      end else if (kind < 93) begin
        send_pool(p, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                  1'($urandom()), {$urandom(), 16'($urandom())}, 16'($urandom()),
                  !(n >= 400 && n < 600));
      end else begin
        send_fragment({$urandom(), 16'($urandom())}, 16'($urandom()),
                      16'($urandom()), 16'($urandom()), 1'($urandom()),
                      {$urandom(), 16'($urandom())}, 16'($urandom()),
                      !(n >= 400 && n < 600));
      end
    end
    start_i <= 1'b0;

    // drain, then allow the longest sample latency to pass
    do @(posedge clk_i); while (pending != 0);
    repeat (60) @(posedge clk_i);

    $display("run covered %0d fragments: %0d bandwidth samples, %0d table-full drops",
             sent_count, sample_count, drop_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ per_host_fragment_bandwidth_estimator.f @@
rtl/phfbe_pkg.sv
rtl/phfbe_datapath.sv
rtl/phfbe_ctrl.sv
rtl/per_host_fragment_bandwidth_estimator.sv
rtl/phfbe_checker.sv
tb/phfbe_checker.sv
tb/tb_top.sv
